// File: design/crc_checked_frame_parser_assert.svh
// Assertion macros for the frame parser port checker.
// No dependencies; taken in by the checker through `include.
`ifndef CRC_CHECKED_FRAME_PARSER_ASSERT_SVH
`define CRC_CHECKED_FRAME_PARSER_ASSERT_SVH

// clocked assertion with asynchronous reset disable and a fixed message
`define CFP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("frame parser port check failed");

// same, with a caller supplied message
`define CFP_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// File: design/cfp_pkg.sv
// Shared constants, types and helper functions of the CRC checked frame parser.
// No dependencies; used by the parser, store, sequencer and checker through cfp_pkg:: names.
package cfp_pkg;

	localparam int STORE_DEPTH       = 256;
	localparam int LONG_MAX_PAYLOAD  = 128;
	localparam int SHORT_MAX_PAYLOAD = 56;
	localparam int CHUNK_PAYLOAD_CAP = 184;
	localparam int CHUNK_ROOM        = 23;

	localparam int LONG_CAP_A  = (LONG_MAX_PAYLOAD < CHUNK_PAYLOAD_CAP) ?
		LONG_MAX_PAYLOAD : CHUNK_PAYLOAD_CAP;
	localparam int LONG_LIMIT  = (LONG_CAP_A < STORE_DEPTH - 7) ? LONG_CAP_A : STORE_DEPTH - 7;
	localparam int SHORT_CAP_A = (SHORT_MAX_PAYLOAD < CHUNK_PAYLOAD_CAP) ?
		SHORT_MAX_PAYLOAD : CHUNK_PAYLOAD_CAP;
	localparam int SHORT_LIMIT = (SHORT_CAP_A < STORE_DEPTH - 6) ? SHORT_CAP_A : STORE_DEPTH - 6;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int UW = $clog2(CHUNK_ROOM + 1);

	localparam int LONG_HDR  = 5;
	localparam int SHORT_HDR = 4;

	localparam logic [7:0]  MAGIC_FIRST  = 8'hA5;
	localparam logic [7:0]  MAGIC_SECOND = 8'h5A;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h1021;

	localparam logic ITEM_CHUNK  = 1'b0;
	localparam logic ITEM_STATUS = 1'b1;
	localparam logic FMT_LONG    = 1'b0;
	localparam logic FMT_SHORT   = 1'b1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic        we;
		addr_t       waddr;
		logic [7:0]  wdata;
		logic        re;
		addr_t       raddr;
	} mem_req_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  frame_type;
		logic [63:0] payload_chunk;
		logic [3:0]  chunk_bytes;
		logic        frame_end;
		logic [31:0] discarded_count;
		logic [31:0] length_error_count;
		logic [31:0] crc_error_count;
		logic        run_last;
	} item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
		logic [15:0] c;
		c = crc_in ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// head plus offset, wrapped into the circular store
	function automatic addr_t addr_wrap(input addr_t head, input cnt_t off);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, off};
		if (sum >= (CW + 1)'(STORE_DEPTH))
			sum = sum - (CW + 1)'(STORE_DEPTH);
		return sum[AW-1:0];
	endfunction

endpackage

// File: design/crc_checked_frame_parser.sv
// Magic/length/CRC-16 frame deframer. One received byte is taken per input word, only
// while the sequencer is idle; it is appended to a circular byte store and the store is
// then parsed byte by byte through its single read port. A byte that completes nothing
// goes through append, magic check and status, with a further read and compare for each
// byte dropped while hunting; header parsing, the CRC over the covered bytes and each
// emitted chunk come after a found magic. A rejected length or CRC drops one byte and
// parses again from the new front, so an error costs a full re-read. Output words stall
// the sequencer only when the output register is still held. header_format is taken only
// while the sequencer is idle, selects the long (16-bit length) or short (8-bit length)
// layout and applies to stored bytes too.
// Depends on cfp_pkg, cfp_store and cfp_seq.
module crc_checked_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        header_format,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [7:0]  frame_type,
	output logic [63:0] payload_chunk,
	output logic [3:0]  chunk_bytes,
	output logic        frame_end,
	output logic [31:0] discarded_count,
	output logic [31:0] length_error_count,
	output logic [31:0] crc_error_count,
	output logic        run_last
);

	logic              fmt_q;
	logic              out_valid_q;
	cfp_pkg::item_t    item_q;
	cfp_pkg::item_t    item;
	cfp_pkg::mem_req_t mem_req;
	logic [7:0]        rdata;
	logic              push;
	logic              out_free;

	assign cfg_ready = in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= cfp_pkg::FMT_LONG;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				fmt_q <= header_format;
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			item_q <= item;
	end

	cfp_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	cfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.fmt       (fmt_q),
		.out_free  (out_free),
		.push      (push),
		.item      (item),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	assign out_valid          = out_valid_q;
	assign item_kind          = item_q.item_kind;
	assign frame_type         = item_q.frame_type;
	assign payload_chunk      = item_q.payload_chunk;
	assign chunk_bytes        = item_q.chunk_bytes;
	assign frame_end          = item_q.frame_end;
	assign discarded_count    = item_q.discarded_count;
	assign length_error_count = item_q.length_error_count;
	assign crc_error_count    = item_q.crc_error_count;
	assign run_last           = item_q.run_last;

endmodule

// File: design/cfp_store.sv
// Circular byte store of the frame parser: one write and one registered read port.
// Depends on cfp_pkg for depth and request type.
module cfp_store (
	input  logic              clk,
	input  cfp_pkg::mem_req_t req,
	output logic [7:0]        rdata
);

	logic [7:0] mem [cfp_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata <= mem[req.raddr];
	end

endmodule

// File: design/cfp_seq.sv
// Sequencer of the frame parser: byte append, magic hunt, header, CRC and chunk output.
// Depends on cfp_pkg; drives cfp_store and the output register in the top level.
module cfp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              fmt,
	input  logic              out_free,
	output logic              push,
	output cfp_pkg::item_t    item,
	output cfp_pkg::mem_req_t mem_req,
	input  logic [7:0]        rdata
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_B0   = 4'd2;
	localparam logic [3:0] S_B1   = 4'd3;
	localparam logic [3:0] S_TAIL = 4'd4;
	localparam logic [3:0] S_HDR  = 4'd5;
	localparam logic [3:0] S_H2   = 4'd6;
	localparam logic [3:0] S_H3   = 4'd7;
	localparam logic [3:0] S_H4   = 4'd8;
	localparam logic [3:0] S_LEN  = 4'd9;
	localparam logic [3:0] S_CRC  = 4'd10;
	localparam logic [3:0] S_E0   = 4'd11;
	localparam logic [3:0] S_E1   = 4'd12;
	localparam logic [3:0] S_PAY  = 4'd13;
	localparam logic [3:0] S_PUSH = 4'd14;
	localparam logic [3:0] S_STAT = 4'd15;

	logic [3:0]           state_q, state_d;
	cfp_pkg::addr_t       head_q, head_d;
	cfp_pkg::cnt_t        count_q, count_d;
	logic [31:0]          drop_q, drop_d, lrej_q, lrej_d, crej_q, crej_d;
	logic                 b0v_q, b0v_d;
	logic [cfp_pkg::UW-1:0] used_q, used_d;

	logic [7:0]           b0_q, b0_d, type_q, type_d, lenlo_q, lenlo_d, explo_q, explo_d;
	logic [15:0]          plen_q, plen_d, crc_q, crc_d;
	cfp_pkg::cnt_t        fsize_q, fsize_d, off_q, off_d, rem_q, rem_d;
	logic [63:0]          acc_q, acc_d;
	logic [3:0]           nb_q, nb_d;

	logic                 rd_en;
	cfp_pkg::cnt_t        rd_off;
	cfp_pkg::cnt_t        hdr, start, fsize_c;
	logic [15:0]          limit;
	logic [cfp_pkg::CW:0] chunk_sum;
	logic [cfp_pkg::UW:0] chunks, need;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		drop_d  = drop_q;
		lrej_d  = lrej_q;
		crej_d  = crej_q;
		b0_d    = b0_q;
		b0v_d   = b0v_q;
		used_d  = used_q;
		type_d  = type_q;
		lenlo_d = lenlo_q;
		explo_d = explo_q;
		plen_d  = plen_q;
		crc_d   = crc_q;
		fsize_d = fsize_q;
		off_d   = off_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		nb_d    = nb_q;
		rd_en   = 1'b0;
		rd_off  = '0;
		push    = 1'b0;
		item    = '0;
		mem_req = '0;

		hdr     = (fmt == cfp_pkg::FMT_SHORT) ? cfp_pkg::cnt_t'(cfp_pkg::SHORT_HDR)
			: cfp_pkg::cnt_t'(cfp_pkg::LONG_HDR);
		start   = (fmt == cfp_pkg::FMT_SHORT) ? cfp_pkg::cnt_t'(0) : cfp_pkg::cnt_t'(2);
		limit   = (fmt == cfp_pkg::FMT_SHORT) ? 16'(cfp_pkg::SHORT_LIMIT)
			: 16'(cfp_pkg::LONG_LIMIT);
		fsize_c = hdr + plen_q[cfp_pkg::CW-1:0] + cfp_pkg::cnt_t'(2);
		chunk_sum = {1'b0, plen_q[cfp_pkg::CW-1:0]} + (cfp_pkg::CW + 1)'(7);
		chunks  = (plen_q == 16'd0) ? (cfp_pkg::UW + 1)'(1)
			: chunk_sum[cfp_pkg::UW+3:3];
		need    = {1'b0, used_q} + chunks;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = data_byte;
					b0v_d         = 1'b0;
					used_d        = '0;
					if (count_q == cfp_pkg::cnt_t'(cfp_pkg::STORE_DEPTH)) begin
						mem_req.waddr = head_q;
						head_d        = cfp_pkg::addr_wrap(head_q, cfp_pkg::cnt_t'(1));
						drop_d        = cfp_pkg::sat_inc(drop_q);
					end else begin
						mem_req.waddr = cfp_pkg::addr_wrap(head_q, count_q);
						count_d       = count_q + cfp_pkg::cnt_t'(1);
					end
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (count_q == '0) begin
					state_d = S_STAT;
				end else if (count_q == cfp_pkg::cnt_t'(1)) begin
					rd_en   = 1'b1;
					state_d = S_TAIL;
				end else if (b0v_q) begin
					rd_en   = 1'b1;
					rd_off  = cfp_pkg::cnt_t'(1);
					state_d = S_B1;
				end else begin
					rd_en   = 1'b1;
					state_d = S_B0;
				end
			end
			S_B0: begin
				b0_d    = rdata;
				b0v_d   = 1'b1;
				rd_en   = 1'b1;
				rd_off  = cfp_pkg::cnt_t'(1);
				state_d = S_B1;
			end
			S_B1: begin
				if (b0_q == cfp_pkg::MAGIC_FIRST && rdata == cfp_pkg::MAGIC_SECOND) begin
					state_d = S_HDR;
				end else begin
					head_d  = cfp_pkg::addr_wrap(head_q, cfp_pkg::cnt_t'(1));
					count_d = count_q - cfp_pkg::cnt_t'(1);
					drop_d  = cfp_pkg::sat_inc(drop_q);
					b0_d    = rdata;
					b0v_d   = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_TAIL: begin
				if (rdata != cfp_pkg::MAGIC_FIRST) begin
					count_d = '0;
					drop_d  = cfp_pkg::sat_inc(drop_q);
				end
				state_d = S_STAT;
			end
			S_HDR: begin
				if (count_q < hdr) begin
					state_d = S_STAT;
				end else begin
					rd_en   = 1'b1;
					rd_off  = cfp_pkg::cnt_t'(2);
					state_d = S_H2;
				end
			end
			S_H2: begin
				type_d  = rdata;
				rd_en   = 1'b1;
				rd_off  = cfp_pkg::cnt_t'(3);
				state_d = S_H3;
			end
			S_H3: begin
				lenlo_d = rdata;
				if (fmt == cfp_pkg::FMT_SHORT) begin
					plen_d  = {8'h00, rdata};
					state_d = S_LEN;
				end else begin
					rd_en   = 1'b1;
					rd_off  = cfp_pkg::cnt_t'(4);
					state_d = S_H4;
				end
			end
			S_H4: begin
				plen_d  = {rdata, lenlo_q};
				state_d = S_LEN;
			end
			S_LEN: begin
				if (plen_q > limit) begin
					lrej_d  = cfp_pkg::sat_inc(lrej_q);
					drop_d  = cfp_pkg::sat_inc(drop_q);
					head_d  = cfp_pkg::addr_wrap(head_q, cfp_pkg::cnt_t'(1));
					count_d = count_q - cfp_pkg::cnt_t'(1);
					b0_d    = cfp_pkg::MAGIC_SECOND;
					b0v_d   = 1'b1;
					state_d = S_SCAN;
				end else if (count_q < fsize_c) begin
					state_d = S_STAT;
				end else begin
					fsize_d = fsize_c;
					crc_d   = cfp_pkg::CRC_INIT;
					rd_en   = 1'b1;
					rd_off  = start;
					off_d   = start + cfp_pkg::cnt_t'(1);
					state_d = S_CRC;
				end
			end
			S_CRC: begin
				crc_d = cfp_pkg::crc_byte(crc_q, rdata);
				rd_en = 1'b1;
				if (off_q == fsize_q - cfp_pkg::cnt_t'(2)) begin
					rd_off  = off_q;
					off_d   = fsize_q - cfp_pkg::cnt_t'(1);
					state_d = S_E0;
				end else begin
					rd_off  = off_q;
					off_d   = off_q + cfp_pkg::cnt_t'(1);
				end
			end
			S_E0: begin
				explo_d = rdata;
				rd_en   = 1'b1;
				rd_off  = off_q;
				state_d = S_E1;
			end
			S_E1: begin
				if ({rdata, explo_q} != crc_q) begin
					crej_d  = cfp_pkg::sat_inc(crej_q);
					drop_d  = cfp_pkg::sat_inc(drop_q);
					head_d  = cfp_pkg::addr_wrap(head_q, cfp_pkg::cnt_t'(1));
					count_d = count_q - cfp_pkg::cnt_t'(1);
					b0_d    = cfp_pkg::MAGIC_SECOND;
					b0v_d   = 1'b1;
					state_d = S_SCAN;
				end else if (need > (cfp_pkg::UW + 1)'(cfp_pkg::CHUNK_ROOM)) begin
					state_d = S_STAT;
				end else begin
					rem_d = plen_q[cfp_pkg::CW-1:0];
					nb_d  = '0;
					acc_d = '0;
					if (plen_q == 16'd0) begin
						state_d = S_PUSH;
					end else begin
						rd_en   = 1'b1;
						rd_off  = hdr;
						off_d   = hdr + cfp_pkg::cnt_t'(1);
						state_d = S_PAY;
					end
				end
			end
			S_PAY: begin
				acc_d[{nb_q[2:0], 3'b000} +: 8] = rdata;
				nb_d  = nb_q + 4'd1;
				rem_d = rem_q - cfp_pkg::cnt_t'(1);
				if (nb_q == 4'd7 || rem_q == cfp_pkg::cnt_t'(1)) begin
					state_d = S_PUSH;
				end else begin
					rd_en  = 1'b1;
					rd_off = off_q;
					off_d  = off_q + cfp_pkg::cnt_t'(1);
				end
			end
			S_PUSH: begin
				if (out_free) begin
					push               = 1'b1;
					item.item_kind     = cfp_pkg::ITEM_CHUNK;
					item.frame_type    = type_q;
					item.payload_chunk = acc_q;
					item.chunk_bytes   = nb_q;
					item.frame_end     = (rem_q == '0);
					used_d             = used_q + cfp_pkg::UW'(1);
					acc_d              = '0;
					nb_d               = '0;
					if (rem_q == '0) begin
						head_d  = cfp_pkg::addr_wrap(head_q, fsize_q);
						count_d = count_q - fsize_q;
						b0v_d   = 1'b0;
						state_d = S_SCAN;
					end else begin
						rd_en   = 1'b1;
						rd_off  = off_q;
						off_d   = off_q + cfp_pkg::cnt_t'(1);
						state_d = S_PAY;
					end
				end
			end
			S_STAT: begin
				if (out_free) begin
					push                    = 1'b1;
					item.item_kind          = cfp_pkg::ITEM_STATUS;
					item.discarded_count    = drop_q;
					item.length_error_count = lrej_q;
					item.crc_error_count    = crej_q;
					item.run_last           = 1'b1;
					state_d                 = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		mem_req.re    = rd_en;
		mem_req.raddr = cfp_pkg::addr_wrap(head_q, rd_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			drop_q  <= '0;
			lrej_q  <= '0;
			crej_q  <= '0;
			b0v_q   <= 1'b0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			drop_q  <= drop_d;
			lrej_q  <= lrej_d;
			crej_q  <= crej_d;
			b0v_q   <= b0v_d;
			used_q  <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		b0_q    <= b0_d;
		type_q  <= type_d;
		lenlo_q <= lenlo_d;
		explo_q <= explo_d;
		plen_q  <= plen_d;
		crc_q   <= crc_d;
		fsize_q <= fsize_d;
		off_q   <= off_d;
		rem_q   <= rem_d;
		acc_q   <= acc_d;
		nb_q    <= nb_d;
	end

endmodule

// File: design/cfp_checker.sv
// Port level checker of the frame parser, bound to the top level.
// Depends on crc_checked_frame_parser_assert.svh and cfp_pkg.
`include "crc_checked_frame_parser_assert.svh"

module cfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        header_format,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        item_kind,
	input logic [7:0]  frame_type,
	input logic [63:0] payload_chunk,
	input logic [3:0]  chunk_bytes,
	input logic        frame_end,
	input logic [31:0] discarded_count,
	input logic [31:0] length_error_count,
	input logic [31:0] crc_error_count,
	input logic        run_last
);

	`CFP_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(payload_chunk) && $stable(discarded_count)))
	`CFP_ASSERT_MSG(a_status_shape, clk, arst_n, (out_valid && item_kind == cfp_pkg::ITEM_STATUS |-> run_last && !frame_end && chunk_bytes == 4'd0 && frame_type == 8'd0 && payload_chunk == 64'd0), "status word carries chunk fields")
	`CFP_ASSERT_MSG(a_chunk_shape, clk, arst_n, (out_valid && item_kind == cfp_pkg::ITEM_CHUNK |-> !run_last && chunk_bytes <= 4'd8 && (chunk_bytes == 4'd8 || frame_end) && discarded_count == 32'd0 && length_error_count == 32'd0 && crc_error_count == 32'd0), "malformed chunk word")
	`CFP_ASSERT(a_in_hold, clk, arst_n, (in_valid && !in_ready |=> in_valid && $stable(data_byte)))
	`CFP_ASSERT_MSG(a_cfg_hold, clk, arst_n, (cfg_valid && !cfg_ready |=> cfg_valid && $stable(header_format)), "config word changed while waiting")

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (.*);
